/* sv/ppp_pkg.sv */
`default_nettype none
package ppp_pkg;

   localparam int MaxVertices = 64;
   localparam int AddrW       = $clog2(MaxVertices);
   localparam int VertexW     = 32;
   localparam int NumW        = 98;
   localparam int DivCntW     = $clog2(NumW);

   typedef enum logic [1:0] {
      CMD_STEP  = 2'd0,
      CMD_RESET = 2'd1,
      CMD_LOAD  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_VERTEX_COUNT = 2'd0,
      CSR_TICKS        = 2'd1,
      CSR_COUNTS       = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIN_RD,
      ST_FIN_MUL,
      ST_RD_A,
      ST_RD_B,
      ST_SEG_D,
      ST_SEG_CHK,
      ST_MUL_D,
      ST_MUL_L,
      ST_MUL_H,
      ST_NUM,
      ST_DIV,
      ST_ACC,
      ST_INT_V,
      ST_INT_P,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

/* sv/ppp_if.sv */
`default_nettype none
interface ppp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic        halt_at_end;
   logic [5:0]  vertex_index;
   logic [15:0] vertex_time;
   logic signed [15:0] vertex_position;

   modport source (output valid, command, halt_at_end, vertex_index, vertex_time,
                   vertex_position, input ready);
   modport sink (input valid, command, halt_at_end, vertex_index, vertex_time,
                 vertex_position, output ready);
endinterface

interface ppp_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [47:0] target_position;
   logic        halted;
   logic        wrapped;
   logic signed [31:0] end_count;

   modport source (output valid, target_position, halted, wrapped, end_count,
                   input ready);
   modport sink (input valid, target_position, halted, wrapped, end_count,
                 output ready);
endinterface

interface ppp_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/ppp_ram.sv */
`default_nettype none
module ppp_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wdata,
   output logic      [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

/* sv/piecewise_position_profile.sv */
// Servo target-position generator with constant acceleration per segment.
// req_chan carries one transaction per command: step tick, reset profile or
// load vertex. rsp_chan returns exactly one transaction per request with the
// target position (Q32.16 counts), the halted and wrapped flags and the end
// count latched by the last reset profile. csr_chan writes vertex_count,
// ticks_per_time_unit and counts_per_position_unit; it is always ready.
// A load vertex writes the table and goes to ST_EMIT; a step inside a segment
// passes through ST_INT_V and ST_INT_P; reset profile and halt read and scale
// the final vertex; a step that opens an empty segment reads its two vertices,
// and one that opens a timed segment also runs the multiplier and divider.
// The segment start is set by the shared 32x32 multiplier (three passes) and
// the 98-step restoring divider that forms the acceleration, one quotient bit
// per cycle. One request is in work at a time; req_chan is ready only while
// the sequencer is idle, so a request is finished before the next is accepted.
// The response sits in an output register, so a new request is taken while
// the previous response waits for rsp_chan.ready. A stalled response holds,
// and the following request then waits in its final cycle until it drains.
// Reset clears the profile state and config registers to their defaults;
// the vertex table is undefined until loaded.
`default_nettype none
module piecewise_position_profile (
   input wire logic clock,
   input wire logic reset,
   ppp_req_if.sink   req_chan,
   ppp_rsp_if.source rsp_chan,
   ppp_csr_if.sink   csr_chan
);
   import ppp_pkg::*;

   state_type state_ff, state_in;

   logic [5:0]  vc_ff, vc_in;
   logic [15:0] tpu_ff, tpu_in;
   logic [15:0] cpu_ff, cpu_in;

   logic [6:0]  seg_ff, seg_in;
   logic [31:0] sidx_ff, sidx_in;
   logic [31:0] scnt_ff, scnt_in;
   logic [63:0] vel_ff, vel_in;
   logic [63:0] vnext_ff, vnext_in;
   logic [63:0] acc_ff, acc_in;
   logic [47:0] pos_ff, pos_in;
   logic [31:0] fin_ff, fin_in;

   logic        fin_mode_ff, fin_mode_in;
   logic        halted_ff, halted_in;
   logic        wrapped_ff, wrapped_in;

   logic [31:0] va_ff, va_in;
   logic [33:0] dt_ff, dt_in;
   logic [33:0] ds_ff, ds_in;
   logic [63:0] d_ff, d_in;
   logic [95:0] pv_ff, pv_in;
   logic [NumW-1:0] num_ff, num_in;
   logic [NumW-1:0] q_ff, q_in;
   logic [63:0] rem_ff, rem_in;
   logic        neg_ff, neg_in;
   logic [DivCntW-1:0] cnt_ff, cnt_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_pos_ff, rsp_pos_in;
   logic        rsp_halted_ff, rsp_halted_in;
   logic        rsp_wrapped_ff, rsp_wrapped_in;
   logic [31:0] rsp_end_ff, rsp_end_in;

   logic               ram_we;
   logic [AddrW-1:0]   ram_addr;
   logic [VertexW-1:0] ram_wdata;
   logic [VertexW-1:0] ram_rdata;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [63:0] vmag;

   logic        req_fire;
   logic [31:0] sidx_inc;
   logic [6:0]  seg_inc;
   logic [32:0] fprod;
   logic [16:0] tdiff, pdiff;
   logic [97:0] pv_s, ds_sh, num_s;
   logic [64:0] r2, r2_sub;
   logic        ge;
   logic        ovf;
   logic [63:0] qsat;
   logic [64:0] vsum;
   logic [64:0] vpair;
   logic [47:0] delta;
   logic [48:0] psum;

   ppp_ram #(.Width(VertexW), .Depth(MaxVertices)) u_table (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.target_position = rsp_pos_ff;
   assign rsp_chan.halted          = rsp_halted_ff;
   assign rsp_chan.wrapped         = rsp_wrapped_ff;
   assign rsp_chan.end_count       = rsp_end_ff;

   assign mul_p = mul_a * mul_b;
   assign vmag  = vel_ff[63] ? (64'd0 - vel_ff) : vel_ff;

   always_comb begin
      state_in       = state_ff;
      vc_in          = vc_ff;
      tpu_in         = tpu_ff;
      cpu_in         = cpu_ff;
      seg_in         = seg_ff;
      sidx_in        = sidx_ff;
      scnt_in        = scnt_ff;
      vel_in         = vel_ff;
      vnext_in       = vnext_ff;
      acc_in         = acc_ff;
      pos_in         = pos_ff;
      fin_in         = fin_ff;
      fin_mode_in    = fin_mode_ff;
      halted_in      = halted_ff;
      wrapped_in     = wrapped_ff;
      va_in          = va_ff;
      dt_in          = dt_ff;
      ds_in          = ds_ff;
      d_in           = d_ff;
      pv_in          = pv_ff;
      num_in         = num_ff;
      q_in           = q_ff;
      rem_in         = rem_ff;
      neg_in         = neg_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_halted_in  = rsp_halted_ff;
      rsp_wrapped_in = rsp_wrapped_ff;
      rsp_end_in     = rsp_end_ff;

      ram_we    = 1'b0;
      ram_addr  = req_chan.vertex_index;
      ram_wdata = {req_chan.vertex_time, req_chan.vertex_position};
      mul_a     = dt_ff[31:0];
      mul_b     = dt_ff[31:0];

      sidx_inc = sidx_ff + 32'd1;
      seg_inc  = seg_ff + 7'd1;
      fprod    = 33'($signed(ram_rdata[15:0]) * $signed({1'b0, cpu_ff}));
      tdiff    = {1'b0, ram_rdata[31:16]} - {1'b0, va_ff[31:16]};
      pdiff    = {ram_rdata[15], ram_rdata[15:0]} - {va_ff[15], va_ff[15:0]};
      pv_s     = vel_ff[63] ? (98'd0 - {2'b00, pv_ff}) : {2'b00, pv_ff};
      ds_sh    = {{31{ds_ff[33]}}, ds_ff, 33'd0};
      num_s    = ds_sh - {pv_s[96:0], 1'b0};
      r2       = {rem_ff, num_ff[NumW-1]};
      ge       = r2 >= {1'b0, d_ff};
      r2_sub   = r2 - {1'b0, d_ff};
      ovf      = neg_ff ? ((|q_ff[97:64]) || (q_ff[63] && (|q_ff[62:0])))
                        : (|q_ff[97:63]);
      qsat     = ovf ? (neg_ff ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : q_ff[63:0];
      vsum     = {vel_ff[63], vel_ff} + {acc_ff[63], acc_ff};
      vpair    = {vel_ff[63], vel_ff} + {vnext_ff[63], vnext_ff};
      delta    = vpair[64:17];
      psum     = {pos_ff[47], pos_ff} + {delta[47], delta};

      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_VERTEX_COUNT: vc_in  = csr_chan.data[5:0];
            CSR_TICKS:        tpu_in = csr_chan.data;
            CSR_COUNTS:       cpu_in = csr_chan.data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               halted_in  = 1'b0;
               wrapped_in = 1'b0;
               unique case (req_chan.command)
                  CMD_STEP: begin
                     if (sidx_inc >= scnt_ff) begin
                        sidx_in = 32'd0;
                        if (seg_inc >= {1'b0, vc_ff}) begin
                           if (req_chan.halt_at_end) begin
                              seg_in      = {1'b0, vc_ff};
                              sidx_in     = scnt_ff;
                              vel_in      = 64'd0;
                              halted_in   = 1'b1;
                              fin_mode_in = 1'b1;
                              state_in    = ST_FIN_RD;
                           end else begin
                              wrapped_in = 1'b1;
                              vel_in     = 64'd0;
                              pos_in     = 48'd0;
                              seg_in     = 7'd0;
                              state_in   = ST_RD_A;
                           end
                        end else begin
                           seg_in   = seg_inc;
                           state_in = ST_RD_A;
                        end
                     end else begin
                        sidx_in  = sidx_inc;
                        state_in = ST_INT_V;
                     end
                  end
                  CMD_RESET: begin
                     seg_in      = 7'h7F;
                     sidx_in     = 32'd0;
                     scnt_in     = 32'd0;
                     vel_in      = 64'd0;
                     acc_in      = 64'd0;
                     pos_in      = 48'd0;
                     fin_mode_in = 1'b0;
                     state_in    = ST_FIN_RD;
                  end
                  CMD_LOAD: begin
                     ram_we   = 1'b1;
                     state_in = ST_EMIT;
                  end
                  default: state_in = ST_EMIT;
               endcase
            end
         end
         ST_FIN_RD: begin
            ram_addr = vc_ff;
            state_in = ST_FIN_MUL;
         end
         ST_FIN_MUL: begin
            if (fin_mode_ff) begin
               pos_in = {fprod[31:0], 16'd0};
            end else begin
               fin_in = fprod[31:0];
            end
            state_in = ST_EMIT;
         end
         ST_RD_A: begin
            ram_addr = seg_ff[AddrW-1:0];
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            ram_addr = seg_inc[AddrW-1:0];
            va_in    = ram_rdata;
            state_in = ST_SEG_D;
         end
         ST_SEG_D: begin
            dt_in    = 34'($signed(tdiff) * $signed({1'b0, tpu_ff}));
            ds_in    = 34'($signed(pdiff) * $signed({1'b0, cpu_ff}));
            state_in = ST_SEG_CHK;
         end
         ST_SEG_CHK: begin
            if (dt_ff[33] || dt_ff == 34'd0) begin
               scnt_in  = 32'd0;
               acc_in   = 64'd0;
               state_in = ST_INT_V;
            end else begin
               scnt_in  = dt_ff[31:0];
               state_in = ST_MUL_D;
            end
         end
         ST_MUL_D: begin
            d_in     = mul_p;
            state_in = ST_MUL_L;
         end
         ST_MUL_L: begin
            mul_a    = vmag[31:0];
            pv_in    = {32'd0, mul_p};
            state_in = ST_MUL_H;
         end
         ST_MUL_H: begin
            mul_a    = vmag[63:32];
            pv_in    = pv_ff + {mul_p, 32'd0};
            state_in = ST_NUM;
         end
         ST_NUM: begin
            neg_in   = num_s[97];
            num_in   = num_s[97] ? (98'd0 - num_s) : num_s;
            q_in     = '0;
            rem_in   = 64'd0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = ge ? r2_sub[63:0] : r2[63:0];
            q_in   = {q_ff[NumW-2:0], ge};
            num_in = {num_ff[NumW-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DivCntW'(NumW - 1)) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            acc_in   = neg_ff ? (64'd0 - qsat) : qsat;
            state_in = ST_INT_V;
         end
         ST_INT_V: begin
            if (vsum[64] != vsum[63]) begin
               vnext_in = vsum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end else begin
               vnext_in = vsum[63:0];
            end
            state_in = ST_INT_P;
         end
         ST_INT_P: begin
            vel_in = vnext_ff;
            if (psum[48] != psum[47]) begin
               pos_in = psum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
            end else begin
               pos_in = psum[47:0];
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_pos_in     = pos_ff;
               rsp_halted_in  = halted_ff;
               rsp_wrapped_in = wrapped_ff;
               rsp_end_in     = fin_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vc_ff        <= 6'd1;
         tpu_ff       <= 16'd1;
         cpu_ff       <= 16'd1;
         seg_ff       <= 7'h7F;
         sidx_ff      <= 32'd0;
         scnt_ff      <= 32'd0;
         vel_ff       <= 64'd0;
         acc_ff       <= 64'd0;
         pos_ff       <= 48'd0;
         fin_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vc_ff        <= vc_in;
         tpu_ff       <= tpu_in;
         cpu_ff       <= cpu_in;
         seg_ff       <= seg_in;
         sidx_ff      <= sidx_in;
         scnt_ff      <= scnt_in;
         vel_ff       <= vel_in;
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vnext_ff       <= vnext_in;
      fin_mode_ff    <= fin_mode_in;
      halted_ff      <= halted_in;
      wrapped_ff     <= wrapped_in;
      va_ff          <= va_in;
      dt_ff          <= dt_in;
      ds_ff          <= ds_in;
      d_ff           <= d_in;
      pv_ff          <= pv_in;
      num_ff         <= num_in;
      q_ff           <= q_in;
      rem_ff         <= rem_in;
      neg_ff         <= neg_in;
      cnt_ff         <= cnt_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_halted_ff  <= rsp_halted_in;
      rsp_wrapped_ff <= rsp_wrapped_in;
      rsp_end_ff     <= rsp_end_in;
   end
endmodule
`default_nettype wire
